>>> design/dss_pkg.sv
// Shared types and constants for the drum step sequencer.
// Used by dss_seq_core, drum_step_sequencer and dss_checker; no dependencies.
`timescale 1ns / 1ps

package dss_pkg;

	// Field and register widths
	localparam int FRAME_W   = 20;
	localparam int PAT_W     = 16;
	localparam int MASK_W    = 4;
	localparam int IDX_W     = 4;
	localparam int REG_COUNT = 4;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;

	// Pattern register reset values, track 0 first
	localparam logic [PAT_W-1:0] PAT_RESET [REG_COUNT] = '{
		16'h1111, 16'h1010, 16'h5555, 16'hFFFF
	};

	// Request kinds carried in tuser
	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_START = 2'd1,
		REQ_STOP  = 2'd2
	} req_type_t;

	// One result item
	typedef struct packed {
		logic              running;
		logic [IDX_W-1:0]  step_index;
		logic [MASK_W-1:0] trigger_mask;
	} dss_result_t;

endpackage

>>> design/dss_seq_core.sv
// Sequencer state (run flag, step, frame counter, trigger arm) and its update.
// Depends on dss_pkg; patterns come from the register bank in the top level.
`timescale 1ns / 1ps

module dss_seq_core import dss_pkg::*; #(
	parameter int STEPS  = 16,
	parameter int TRACKS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  req_type_t         req,
	input  logic [FRAME_W-1:0] frames,
	input  logic [PAT_W-1:0]  pattern [(TRACKS < REG_COUNT) ? TRACKS : REG_COUNT],
	output dss_result_t       result
);

	localparam int NUM_PAT = (TRACKS < REG_COUNT) ? TRACKS : REG_COUNT;
	localparam int POS_W   = $clog2(STEPS);

	logic               run_q, run_d;
	logic               armed_q, armed_d;
	logic [POS_W-1:0]   pos_q, pos_d, pos_inc;
	logic [FRAME_W-1:0] frame_q, frame_d, frame_inc;
	logic [FRAME_W-1:0] len_q, len_d, len_eff;
	logic               wrap;
	logic [MASK_W-1:0]  fire, mask;
	logic [7:0]         pos_cur8, pos_next8;

	// Mask of tracks whose pattern bit is set at the current step
	always_comb begin
		pos_cur8 = 8'(pos_q);
		fire = '0;
		for (int t = 0; t < NUM_PAT; t++) begin
			fire[t] = (pos_cur8 < 8'd16) && pattern[t][pos_cur8[3:0]];
		end
	end

	// Frame and step advance
	assign len_eff   = (len_q == '0) ? FRAME_W'(1) : len_q;
	assign frame_inc = frame_q + FRAME_W'(1);
	assign wrap      = (frame_inc >= len_eff) || (frame_inc == '0);
	assign pos_inc   = (pos_q == POS_W'(STEPS - 1)) ? '0 : pos_q + POS_W'(1);

	// Next state per request kind
	always_comb begin
		run_d   = run_q;
		armed_d = armed_q;
		pos_d   = pos_q;
		frame_d = frame_q;
		len_d   = len_q;
		mask    = '0;
		case (req)
			REQ_START: begin
				if (!run_q) begin
					pos_d   = '0;
					frame_d = '0;
					len_d   = (frames == '0) ? FRAME_W'(1) : frames;
					armed_d = 1'b1;
					run_d   = 1'b1;
				end
			end
			REQ_STOP: begin
				run_d = 1'b0;
			end
			REQ_TICK: begin
				if (run_q) begin
					if (armed_q) begin
						mask    = fire;
						armed_d = 1'b0;
					end
					frame_d = frame_inc;
					if (wrap) begin
						frame_d = '0;
						pos_d   = pos_inc;
						armed_d = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// Result fields reflect the state after this item
	always_comb begin
		pos_next8           = 8'(pos_d);
		result.trigger_mask = mask;
		result.step_index   = pos_next8[IDX_W-1:0];
		result.running      = run_d;
	end

	// Commit state on each accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			armed_q <= 1'b0;
			pos_q   <= '0;
			frame_q <= '0;
			len_q   <= '0;
		end else if (en) begin
			run_q   <= run_d;
			armed_q <= armed_d;
			pos_q   <= pos_d;
			frame_q <= frame_d;
			len_q   <= len_d;
		end
	end

endmodule

>>> design/drum_step_sequencer.sv
// Drum step sequencer top level: stream ports, APB pattern registers, output register.
// Depends on dss_pkg and dss_seq_core.
//
// Usage:
//   Input stream (s_axis_*): one transfer per request. tuser holds the request
//   kind (sample tick, start, stop); tdata holds the step length in frames,
//   read only by a start. Start while playing and stop while stopped do nothing.
//   Output stream (m_axis_*): exactly one transfer per input transfer, in order,
//   carrying the trigger mask, the step index after the request and the run flag.
//   Output valid rises in the cycle after the input transfer. Throughput is one
//   request per cycle unless stalled: the state update and mask lookup are a
//   single combinational pass between the sequencer state and the output register.
//   When the receiver stalls, the output register holds its transfer and
//   s_axis_tready drops until it is taken; no result is lost or repeated.
//   APB port: four 16-bit track patterns at byte offsets 0, 4, 8, 12; bit n
//   is step n. Write only while the stream is idle. pready is always high.
//   Reset (arst_n low) stops playback, clears step, frame count and trigger,
//   and loads the default patterns.
`timescale 1ns / 1ps

module drum_step_sequencer import dss_pkg::*; #(
	parameter int STEPS  = 16,
	parameter int TRACKS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [19:0] step_frames, [23:20] zero
	input  logic [1:0]           s_axis_tuser,  // [1:0] req_type
	// Output stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // [3:0] trigger_mask, [7:4] step_index,
	                                            // [8] running, [15:9] zero
	// Configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready
);

	localparam int NUM_PAT = (TRACKS < REG_COUNT) ? TRACKS : REG_COUNT;

	logic             in_xfer;
	logic             cfg_wr;
	logic [1:0]       reg_idx;
	logic [PAT_W-1:0] pat_q [NUM_PAT];
	dss_result_t      core_res;
	dss_result_t      out_q;
	logic             out_valid_q;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	// Pattern register bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PAT; i++) begin
				pat_q[i] <= PAT_RESET[i];
			end
		end else begin
			for (int i = 0; i < NUM_PAT; i++) begin
				if (cfg_wr && (reg_idx == 2'(i))) begin
					pat_q[i] <= pwdata[PAT_W-1:0];
				end
			end
		end
	end

	// Register read; absent tracks read as zero
	always_comb begin
		prdata = '0;
		for (int i = 0; i < NUM_PAT; i++) begin
			if (reg_idx == 2'(i)) begin
				prdata = DATA_W'(pat_q[i]);
			end
		end
	end

	// Accept while the output register is empty or being drained
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	dss_seq_core #(
		.STEPS  (STEPS),
		.TRACKS (TRACKS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (in_xfer),
		.req     (req_type_t'(s_axis_tuser)),
		.frames  (s_axis_tdata[FRAME_W-1:0]),
		.pattern (pat_q),
		.result  (core_res)
	);

	// Output register: load on input transfer, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_q <= core_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = M_TDATA_W'(out_q);

endmodule

>>> design/dss_checker.sv
// Port-level checks for drum_step_sequencer, attached by bind.
// Depends on dss_pkg for port widths.
`timescale 1ns / 1ps

module dss_checker import dss_pkg::*; #(
	parameter int STEPS = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata
);

	// A stalled result holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transfer changed while stalled");

	// Every input transfer shows a result on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("result missing one cycle after input transfer");

	// Triggers fire only while playing
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[3:0] != 4'd0) |-> m_axis_tdata[8])
		else $error("trigger reported while stopped");

	// Step index stays within the sequence length
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (STEPS > 16) || (32'(m_axis_tdata[7:4]) < STEPS))
		else $error("step index out of range");

endmodule

bind drum_step_sequencer dss_checker #(
	.STEPS (STEPS)
) u_dss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
